// ===== hdl/obsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsc_pkg: shared types and constants of the optical bypass switch controller
// Word formats, configuration and state records, command, rule, status and
// register index codes.
// ----------------------------------------------------------------------------
package obsc_pkg;

    localparam int RET_TIMER_W  = 18;
    localparam int AUTO_TIMER_W = 24;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;

    // Command codes
    localparam logic [1:0] CMD_EVAL     = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_SET_MODE = 2'd2;

    // Link status codes
    localparam logic [1:0] ST_BOTH_DARK   = 2'd0;
    localparam logic [1:0] ST_SECOND_LIT  = 2'd1;
    localparam logic [1:0] ST_FIRST_LIT   = 2'd2;
    localparam logic [1:0] ST_BOTH_LIT    = 2'd3;

    // Rule codes (bypass rule names what is dark, return rule what is lit)
    localparam logic [2:0] RULE_BOTH   = 3'd1;
    localparam logic [2:0] RULE_FIRST  = 3'd2;
    localparam logic [2:0] RULE_SECOND = 3'd3;
    localparam logic [2:0] RULE_EITHER = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_FIRST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_SECOND = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BYPASS_RULE      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RETURN_RULE      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RETURN_ENABLE    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RETURN_DELAY_SEC = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_RETURN_MIN  = 3'd6;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [15:0]  power_first;
        logic signed [15:0]  power_second;
        logic                mode_value;
    } in_word_t;

    typedef struct packed {
        logic       bypass;
        logic       auto_mode;
        logic       buzzer_pulse;
        logic [1:0] link_status;
    } out_word_t;

    typedef struct packed {
        logic signed [15:0] threshold_first;
        logic signed [15:0] threshold_second;
        logic [2:0]         bypass_rule;
        logic [2:0]         return_rule;
        logic               return_enable;
        logic [7:0]         return_delay_sec;
        logic [7:0]         auto_return_min;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              prev_status;
        logic                    bypass;
        logic                    mode;
        logic [RET_TIMER_W-1:0]  return_timer;
        logic [AUTO_TIMER_W-1:0] auto_timer;
    } state_t;

endpackage

// ===== hdl/obsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsc_cfg_regs: configuration register file
// Plain indexed write port, no read-back; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module obsc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [obsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [obsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output obsc_pkg::cfg_t                 cfg
);

    obsc_pkg::cfg_t cfg_reg;
    obsc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                obsc_pkg::REG_THRESHOLD_FIRST:  cfg_next.threshold_first  = cfg_wdata;
                obsc_pkg::REG_THRESHOLD_SECOND: cfg_next.threshold_second = cfg_wdata;
                obsc_pkg::REG_BYPASS_RULE:      cfg_next.bypass_rule      = cfg_wdata[2:0];
                obsc_pkg::REG_RETURN_RULE:      cfg_next.return_rule      = cfg_wdata[2:0];
                obsc_pkg::REG_RETURN_ENABLE:    cfg_next.return_enable    = cfg_wdata[0];
                obsc_pkg::REG_RETURN_DELAY_SEC: cfg_next.return_delay_sec = cfg_wdata[7:0];
                obsc_pkg::REG_AUTO_RETURN_MIN:  cfg_next.auto_return_min  = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_first  <= '0;
            cfg_reg.threshold_second <= '0;
            cfg_reg.bypass_rule      <= obsc_pkg::RULE_BOTH;
            cfg_reg.return_rule      <= obsc_pkg::RULE_BOTH;
            cfg_reg.return_enable    <= 1'b1;
            cfg_reg.return_delay_sec <= '0;
            cfg_reg.auto_return_min  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/obsc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsc_step: single-pass update of the link controller
// Classifies the samples, applies bypass and return rules, advances and
// checks the return and auto-return timers, or sets the mode, for one word.
// ----------------------------------------------------------------------------
module obsc_step #(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int TICKS_PER_MINUTE = 60000
) (
    input  obsc_pkg::in_word_t  word,
    input  obsc_pkg::cfg_t      cfg,
    input  obsc_pkg::state_t    st,
    output obsc_pkg::state_t    st_next,
    output obsc_pkg::out_word_t result
);

    localparam int RPW = 8 + $clog2(TICKS_PER_SECOND + 1);
    localparam int APW = 8 + $clog2(TICKS_PER_MINUTE + 1);
    localparam int RCW = (RPW > obsc_pkg::RET_TIMER_W) ? RPW : obsc_pkg::RET_TIMER_W;
    localparam int ACW = (APW > obsc_pkg::AUTO_TIMER_W) ? APW : obsc_pkg::AUTO_TIMER_W;
    localparam logic [obsc_pkg::RET_TIMER_W-1:0]  RET_MAX  = '1;
    localparam logic [obsc_pkg::AUTO_TIMER_W-1:0] AUTO_MAX = '1;

    logic [RPW-1:0] ret_prod;
    logic [APW-1:0] auto_prod;
    logic           lit_first;
    logic           lit_second;
    logic [1:0]     status;
    logic [2:0]     byp_code;
    logic [2:0]     ret_code;
    logic           buzz;

    // Timer expires when value >= product + 1, i.e. value > product
    assign ret_prod  = RPW'(cfg.return_delay_sec) * RPW'(TICKS_PER_SECOND);
    assign auto_prod = APW'(cfg.auto_return_min) * APW'(TICKS_PER_MINUTE);

    assign lit_first  = word.power_first  > cfg.threshold_first;
    assign lit_second = word.power_second > cfg.threshold_second;

    always_comb begin
        st_next  = st;
        status   = st.prev_status;
        buzz     = 1'b0;
        byp_code = obsc_pkg::RULE_SECOND;
        ret_code = obsc_pkg::RULE_FIRST;
        case (word.cmd)
            obsc_pkg::CMD_EVAL: begin
                status = {lit_first, lit_second};
                if (st.mode) begin
                    st_next.auto_timer = '0;
                    if (status != st.prev_status) begin
                        st_next.return_timer = '0;
                        if (status == obsc_pkg::ST_BOTH_DARK) begin
                            st_next.bypass = 1'b1;
                        end else if (status == obsc_pkg::ST_BOTH_LIT) begin
                            if (cfg.return_enable) begin
                                st_next.return_timer = obsc_pkg::RET_TIMER_W'(1);
                            end
                        end else begin
                            // first lit: second dark; second lit: first dark
                            byp_code = (status == obsc_pkg::ST_FIRST_LIT) ?
                                       obsc_pkg::RULE_SECOND : obsc_pkg::RULE_FIRST;
                            ret_code = (status == obsc_pkg::ST_FIRST_LIT) ?
                                       obsc_pkg::RULE_FIRST : obsc_pkg::RULE_SECOND;
                            if (cfg.bypass_rule == byp_code ||
                                cfg.bypass_rule == obsc_pkg::RULE_EITHER) begin
                                st_next.bypass = 1'b1;
                            end else if (cfg.return_rule == ret_code ||
                                         cfg.return_rule == obsc_pkg::RULE_EITHER) begin
                                if (cfg.return_enable) begin
                                    st_next.return_timer = obsc_pkg::RET_TIMER_W'(1);
                                end
                            end
                        end
                        st_next.prev_status = status;
                    end
                    if (status != obsc_pkg::ST_BOTH_DARK &&
                        RCW'(st_next.return_timer) > RCW'(ret_prod)) begin
                        st_next.return_timer = '0;
                        st_next.bypass       = 1'b0;
                    end
                end else begin
                    st_next.return_timer = '0;
                    if (cfg.auto_return_min != 8'd0 && st.auto_timer == '0) begin
                        st_next.auto_timer = obsc_pkg::AUTO_TIMER_W'(1);
                    end
                    if (ACW'(st_next.auto_timer) > ACW'(auto_prod)) begin
                        st_next.auto_timer = '0;
                        st_next.mode       = 1'b1;
                        buzz               = 1'b1;
                    end
                end
            end
            obsc_pkg::CMD_TICK: begin
                if (st.return_timer != '0 && st.return_timer != RET_MAX) begin
                    st_next.return_timer = st.return_timer + 1'b1;
                end
                if (st.auto_timer != '0 && st.auto_timer != AUTO_MAX) begin
                    st_next.auto_timer = st.auto_timer + 1'b1;
                end
            end
            obsc_pkg::CMD_SET_MODE: begin
                st_next.mode = word.mode_value;
            end
            default: ;
        endcase
    end

    assign result.bypass       = st_next.bypass;
    assign result.auto_mode    = st_next.mode;
    assign result.buzzer_pulse = buzz;
    assign result.link_status  = status;

endmodule

// ===== hdl/optical_bypass_switch_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_bypass_switch_controller_unit: bypass switch control for one link
// Input register, single-pass state update, result register.
// ----------------------------------------------------------------------------
// One word per clock, sustained while the result side is ready. Each input
// word (evaluate, millisecond tick or set mode) is captured in an input
// register; when it advances, the step logic updates the controller state
// and loads exactly one result word into the output register, which raises
// m_valid; the result is taken at a clock edge with m_ready high. The rate
// is set by the single state update per cycle: the controller state is
// written once for every word that moves from the input register to the
// output register. A full output register with m_ready low holds the pipe;
// the input register still takes a word while it is empty. Configuration is
// written through cfg_wr_en, cfg_addr and cfg_wdata and should only change
// while no word is in flight.
module optical_bypass_switch_controller_unit #(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int TICKS_PER_MINUTE = 60000
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [obsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [obsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input word channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  obsc_pkg::in_word_t              s_data,
    // result word channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output obsc_pkg::out_word_t             m_data
);

    obsc_pkg::cfg_t      cfg;
    obsc_pkg::state_t    state_reg;
    obsc_pkg::state_t    state_next;
    obsc_pkg::out_word_t step_result;

    logic                in_valid_reg;
    obsc_pkg::in_word_t  in_data_reg;
    logic                out_valid_reg;
    obsc_pkg::out_word_t out_data_reg;
    logic                advance;

    obsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    obsc_step #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
    ) u_step (
        .word    (in_data_reg),
        .cfg     (cfg),
        .st      (state_reg),
        .st_next (state_next),
        .result  (step_result)
    );

    // Advance the held word when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register: hold the word until it moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Controller state: commit only when a word advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.prev_status  <= obsc_pkg::ST_BOTH_DARK;
            state_reg.bypass       <= 1'b1;
            state_reg.mode         <= 1'b1;
            state_reg.return_timer <= '0;
            state_reg.auto_timer   <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register: drop the valid once taken, load on advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for optical_bypass_switch_controller_unit
// Drives evaluate, tick, set-mode and spare words through the input channel.
// A cycle-free predictor of the switch controller runs beside the unit, and
// every result word is checked field by field against it. Phases change the
// configuration and the amount of idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int TICKS_PER_MINUTE = 60000;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int RANDOM_PHASES    = 8;
    localparam int WORDS_PER_PHASE  = 120;
    localparam int DRAIN_CYCLES     = 4;

    // The package names no code for the fourth command; it must do nothing.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Idle patterns of the two channels
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [obsc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [obsc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    obsc_pkg::in_word_t  s_data;
    logic        m_valid;
    logic        m_ready;
    obsc_pkg::out_word_t m_data;

    // Words waiting to be offered, and the results they must produce
    obsc_pkg::in_word_t  word_q[$];
    obsc_pkg::out_word_t switch_results_q[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  in_fire;
    int  err_count;
    int  cycle_count;

    // Predicted controller state and configuration
    obsc_pkg::cfg_t                    lk_cfg;
    logic [1:0]                        lk_prev_cls;
    logic                              lk_bypass;
    logic                              lk_auto;
    logic [obsc_pkg::RET_TIMER_W-1:0]  lk_ret_tmr;
    logic [obsc_pkg::AUTO_TIMER_W-1:0] lk_auto_tmr;

    optical_bypass_switch_controller_unit #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor: advance the controller state by one word and return the
    // result word it must produce.
    // ------------------------------------------------------------------------
    function automatic void arm_return_timer();
        if (lk_cfg.return_enable && lk_ret_tmr == '0) begin
            lk_ret_tmr = obsc_pkg::RET_TIMER_W'(1);
        end
    endfunction

    function automatic obsc_pkg::out_word_t link_result(obsc_pkg::in_word_t w);
        obsc_pkg::out_word_t r;
        logic [1:0]  cls;
        logic        buzz;
        logic        lit_a;
        logic        lit_b;
        logic [2:0]  dark_code;
        logic [2:0]  lit_code;
        int unsigned ret_lim;
        int unsigned auto_lim;
        cls      = lk_prev_cls;
        buzz     = 1'b0;
        ret_lim  = lk_cfg.return_delay_sec * TICKS_PER_SECOND + 1;
        auto_lim = lk_cfg.auto_return_min * TICKS_PER_MINUTE + 1;
        case (w.cmd)
            obsc_pkg::CMD_EVAL: begin
                lit_a = w.power_first > lk_cfg.threshold_first;
                lit_b = w.power_second > lk_cfg.threshold_second;
                cls   = {lit_a, lit_b};
                if (lk_auto) begin
                    lk_auto_tmr = '0;
                    if (cls != lk_prev_cls) begin
                        lk_ret_tmr = '0;
                        if (cls == obsc_pkg::ST_BOTH_DARK) begin
                            lk_bypass = 1'b1;
                        end else if (cls == obsc_pkg::ST_BOTH_LIT) begin
                            // both lit arms the timer whatever the return rule says
                            arm_return_timer();
                        end else begin
                            dark_code = (cls == obsc_pkg::ST_FIRST_LIT) ?
                                        obsc_pkg::RULE_SECOND : obsc_pkg::RULE_FIRST;
                            lit_code  = (cls == obsc_pkg::ST_FIRST_LIT) ?
                                        obsc_pkg::RULE_FIRST : obsc_pkg::RULE_SECOND;
                            if (lk_cfg.bypass_rule == dark_code ||
                                lk_cfg.bypass_rule == obsc_pkg::RULE_EITHER) begin
                                lk_bypass = 1'b1;
                            end else if (lk_cfg.return_rule == lit_code ||
                                         lk_cfg.return_rule == obsc_pkg::RULE_EITHER) begin
                                arm_return_timer();
                            end
                        end
                        lk_prev_cls = cls;
                    end
                    if (cls != obsc_pkg::ST_BOTH_DARK && lk_ret_tmr >= ret_lim) begin
                        lk_ret_tmr = '0;
                        lk_bypass  = 1'b0;
                    end
                end else begin
                    // manual: previous class is kept, return timer dropped
                    lk_ret_tmr = '0;
                    if (lk_cfg.auto_return_min != 8'd0 && lk_auto_tmr == '0) begin
                        lk_auto_tmr = obsc_pkg::AUTO_TIMER_W'(1);
                    end
                    if (lk_auto_tmr >= auto_lim) begin
                        lk_auto_tmr = '0;
                        lk_auto     = 1'b1;
                        buzz        = 1'b1;
                    end
                end
            end
            obsc_pkg::CMD_TICK: begin
                if (lk_ret_tmr != '0 && lk_ret_tmr != '1) begin
                    lk_ret_tmr = lk_ret_tmr + 1'b1;
                end
                if (lk_auto_tmr != '0 && lk_auto_tmr != '1) begin
                    lk_auto_tmr = lk_auto_tmr + 1'b1;
                end
            end
            obsc_pkg::CMD_SET_MODE: begin
                lk_auto = w.mode_value;
            end
            default: begin
            end
        endcase
        r.bypass       = lk_bypass;
        r.auto_mode    = lk_auto;
        r.buzzer_pulse = buzz;
        r.link_status  = cls;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic obsc_pkg::in_word_t make_word(logic [1:0] c, logic [15:0] pa,
                                                     logic [15:0] pb, logic mv);
        obsc_pkg::in_word_t w;
        w.cmd          = c;
        w.power_first  = pa;
        w.power_second = pb;
        w.mode_value   = mv;
        return w;
    endfunction

    // Powers cluster round the threshold so that the class flips often.
    function automatic logic [15:0] pick_power(logic [15:0] thr);
        logic [15:0] p;
        case ($urandom_range(9))
            0, 1, 2, 3: p = 16'($urandom);
            4, 5, 6:    p = thr + 16'($urandom_range(4)) - 16'd2;
            7:          p = 16'h8000;
            8:          p = 16'h7fff;
            default:    p = thr;
        endcase
        return p;
    endfunction

    function automatic logic [15:0] pick_threshold();
        logic [15:0] t;
        case ($urandom_range(5))
            0:       t = 16'h8000;
            1:       t = 16'h7fff;
            2, 3:    t = 16'($urandom_range(400)) - 16'd200;
            default: t = 16'($urandom);
        endcase
        return t;
    endfunction

    function automatic obsc_pkg::in_word_t random_word();
        obsc_pkg::in_word_t w;
        int       r;
        w = make_word(2'($urandom), pick_power(lk_cfg.threshold_first),
                      pick_power(lk_cfg.threshold_second), 1'($urandom));
        r = $urandom_range(99);
        if (r < 50) begin
            w.cmd = obsc_pkg::CMD_EVAL;
        end else if (r < 80) begin
            w.cmd = obsc_pkg::CMD_TICK;
        end else if (r < 93) begin
            w.cmd        = obsc_pkg::CMD_SET_MODE;
            w.mode_value = ($urandom_range(99) < 65);
        end else begin
            w.cmd = CMD_SPARE;
        end
        return w;
    endfunction

    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++) begin
            word_q.push_back(make_word(obsc_pkg::CMD_TICK, 16'($urandom), 16'($urandom),
                                       1'($urandom)));
        end
    endtask

    task automatic push_eval(logic [15:0] pa, logic [15:0] pb);
        word_q.push_back(make_word(obsc_pkg::CMD_EVAL, pa, pb, 1'($urandom)));
    endtask

    task automatic push_mode(logic mv);
        word_q.push_back(make_word(obsc_pkg::CMD_SET_MODE, 16'($urandom), 16'($urandom), mv));
    endtask

    // ------------------------------------------------------------------------
    // Configuration, idling and draining
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [obsc_pkg::CFG_ADDR_W-1:0] idx,
                             logic [obsc_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            obsc_pkg::REG_THRESHOLD_FIRST:  lk_cfg.threshold_first  = val;
            obsc_pkg::REG_THRESHOLD_SECOND: lk_cfg.threshold_second = val;
            obsc_pkg::REG_BYPASS_RULE:      lk_cfg.bypass_rule      = val[2:0];
            obsc_pkg::REG_RETURN_RULE:      lk_cfg.return_rule      = val[2:0];
            obsc_pkg::REG_RETURN_ENABLE:    lk_cfg.return_enable    = val[0];
            obsc_pkg::REG_RETURN_DELAY_SEC: lk_cfg.return_delay_sec = val[7:0];
            obsc_pkg::REG_AUTO_RETURN_MIN:  lk_cfg.auto_return_min  = val[7:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_config(logic [15:0] ta, logic [15:0] tb_, logic [2:0] byp,
                                logic [2:0] ret, logic en, logic [7:0] dly, logic [7:0] mins);
        write_reg(obsc_pkg::REG_THRESHOLD_FIRST, ta);
        write_reg(obsc_pkg::REG_THRESHOLD_SECOND, tb_);
        write_reg(obsc_pkg::REG_BYPASS_RULE, {13'd0, byp});
        write_reg(obsc_pkg::REG_RETURN_RULE, {13'd0, ret});
        write_reg(obsc_pkg::REG_RETURN_ENABLE, {15'd0, en});
        write_reg(obsc_pkg::REG_RETURN_DELAY_SEC, {8'd0, dly});
        write_reg(obsc_pkg::REG_AUTO_RETURN_MIN, {8'd0, mins});
        @(posedge aclk);
    endtask

    task automatic set_idle(idle_mode_t m);
        case (m)
            IDLE_SENDER:   begin send_idle_pct = 57; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            IDLE_BOTH:     begin send_idle_pct = 34; recv_stall_pct = 34; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Hold until every queued word is taken and every result has come back.
    task automatic drain();
        while (word_q.size() != 0 || s_valid || switch_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge only.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            // previous word gone: offer the next one or idle
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= word_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        obsc_pkg::out_word_t want;
        in_fire = aresetn && s_valid && s_ready;
        if (in_fire) begin
            switch_results_q.push_back(link_result(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (switch_results_q.size() == 0) begin
                $display("%0t: result word with nothing expected, got %p", $time, m_data);
                err_count++;
            end else begin
                want = switch_results_q.pop_front();
                if (m_data.bypass !== want.bypass ||
                    m_data.auto_mode !== want.auto_mode ||
                    m_data.buzzer_pulse !== want.buzzer_pulse ||
                    m_data.link_status !== want.link_status) begin
                    $display("%0t: result mismatch, expected %p, got %p",
                             $time, want, m_data);
                    err_count++;
                end
            end
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL optical_bypass_switch_controller_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] ta;
        logic [15:0] tb_;
        logic [2:0]  byp;
        logic [2:0]  ret;
        logic [7:0]  dly;
        logic [7:0]  mins;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        err_count = 0;
        cycle_count = 0;
        set_idle(IDLE_NONE);

        // predictor starts from the reset state
        lk_cfg.threshold_first  = '0;
        lk_cfg.threshold_second = '0;
        lk_cfg.bypass_rule      = obsc_pkg::RULE_BOTH;
        lk_cfg.return_rule      = obsc_pkg::RULE_BOTH;
        lk_cfg.return_enable    = 1'b1;
        lk_cfg.return_delay_sec = '0;
        lk_cfg.auto_return_min  = '0;
        lk_prev_cls = obsc_pkg::ST_BOTH_DARK;
        lk_bypass   = 1'b1;
        lk_auto     = 1'b1;
        lk_ret_tmr  = '0;
        lk_auto_tmr = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: dark on dark, lit at the limits, zero delay return,
        // half-lit classes under the both rules, spare command, manual evaluate.
        push_eval(16'h8000, 16'h8000);
        push_eval(16'h7fff, 16'h7fff);
        push_eval(16'h0000, 16'h0000);
        push_eval(16'h0001, 16'h0000);
        push_eval(16'h0000, 16'h0001);
        push_ticks(1);
        word_q.push_back(make_word(CMD_SPARE, 16'hffff, 16'hffff, 1'b1));
        push_mode(1'b0);
        push_eval(16'h7fff, 16'hffff);
        push_mode(1'b1);
        push_eval(16'hffff, 16'h7fff);
        drain();

        // Extreme thresholds, either rules, one-minute auto return armed in manual
        set_idle(IDLE_SENDER);
        write_config(16'h8000, 16'h7fff, obsc_pkg::RULE_EITHER, obsc_pkg::RULE_EITHER,
                     1'b1, 8'd0, 8'd1);
        push_eval(16'h7fff, 16'h7fff);
        push_eval(16'h8000, 16'h8000);
        push_mode(1'b0);
        push_eval(16'h0000, 16'h0000);
        push_ticks(1);
        drain();

        // Dropping the minute setting to zero while the timer runs: next manual
        // evaluate restores auto mode with a buzzer pulse.
        set_idle(IDLE_RECEIVER);
        write_reg(obsc_pkg::REG_AUTO_RETURN_MIN, 16'd0);
        @(posedge aclk);
        push_eval(16'h0000, 16'h0000);
        drain();

        // Short runs of both timers at one minute and one second: no expiry
        set_idle(IDLE_NONE);
        write_config(16'h0000, 16'h0000, obsc_pkg::RULE_FIRST, obsc_pkg::RULE_SECOND,
                     1'b1, 8'd1, 8'd1);
        push_mode(1'b0);
        push_eval(16'd100, -16'sd100);
        push_ticks(3);
        push_eval(16'd100, -16'sd100);
        push_mode(1'b1);
        push_eval(-16'sd5, -16'sd5);
        push_eval(16'd5, 16'd5);
        push_ticks(3);
        push_eval(16'd5, 16'd5);
        push_eval(16'd5, -16'sd5);
        push_eval(-16'sd5, 16'd5);
        drain();

        // Zero delay: the return follows on the evaluate that arms the timer
        write_reg(obsc_pkg::REG_RETURN_DELAY_SEC, 16'd0);
        @(posedge aclk);
        push_eval(-16'sd5, -16'sd5);
        push_eval(16'd5, 16'd5);
        push_eval(16'd5, -16'sd5);
        drain();

        // Random phases; spare rule codes first, then the legal ones
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_idle(idle_mode_t'(p % 4));
            ta  = pick_threshold();
            tb_ = pick_threshold();
            case (p)
                0:       begin byp = 3'd7; ret = 3'd0; end
                1:       begin byp = 3'd5; ret = 3'd6; end
                2:       begin byp = 3'd0; ret = 3'd7; end
                default: begin byp = 3'($urandom_range(4, 1)); ret = 3'($urandom_range(4, 1)); end
            endcase
            case (p % 4)
                0:       dly = 8'd0;
                1:       dly = 8'd1;
                2:       dly = 8'd255;
                default: dly = 8'($urandom_range(254, 2));
            endcase
            case (p % 3)
                0:       mins = 8'd0;
                1:       mins = 8'd255;
                default: mins = 8'd1;
            endcase
            write_config(ta, tb_, byp, ret, (p % 3) != 2, dly, mins);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if ($urandom_range(99) < 2) begin
                    // short run of ticks, then look at the link again
                    push_ticks($urandom_range(5, 2));
                    push_eval(pick_power(lk_cfg.threshold_first),
                              pick_power(lk_cfg.threshold_second));
                end else begin
                    word_q.push_back(random_word());
                end
            end
            drain();
        end

        if (err_count == 0) begin
            $display("PASS optical_bypass_switch_controller_unit");
        end else begin
            $display("FAIL optical_bypass_switch_controller_unit");
        end
        $finish;
    end

endmodule
